// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL modules.
// Every check is sampled on the rising clock and is disabled while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property that has to hold on every clock.
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/armt_pkg.sv =====
// ----------------------------------------------------------------------------
// armt_pkg
// Types and constants shared by the address range merge table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package armt_pkg;

	localparam int unsigned MAX_RANGES_DEF = 64;
	localparam logic [31:0] HITS_MAX       = 32'hFFFF_FFFF;

	// command field codes
	localparam logic CMD_ADD  = 1'b0;
	localparam logic CMD_READ = 1'b1;

	typedef enum logic [2:0] {
		ST_MERGED    = 3'd0,
		ST_INSERTED  = 3'd1,
		ST_EMPTY     = 3'd2,
		ST_FULL      = 3'd3,
		ST_READ_OK   = 3'd4,
		ST_BAD_INDEX = 3'd5
	} status_t;

	// one table entry as stored in the memory
	typedef struct packed {
		logic [63:0] lo;
		logic [63:0] hi;
		logic [31:0] hits;
	} entry_t;

	// memory read request
	typedef enum logic [1:0] {
		RD_NONE  = 2'd0,
		RD_FIRST = 2'd1,
		RD_NEXT  = 2'd2,
		RD_INDEX = 2'd3
	} rd_sel_t;

	// result action: what the datapath writes back and reports
	typedef enum logic [2:0] {
		ACT_NONE  = 3'd0,
		ACT_EMPTY = 3'd1,
		ACT_BAD   = 3'd2,
		ACT_READ  = 3'd3,
		ACT_MERGE = 3'd4,
		ACT_TAIL  = 3'd5
	} act_t;

	typedef struct packed {
		logic    load;
		rd_sel_t rd_sel;
		act_t    act;
	} dp_cmd_t;

	typedef struct packed {
		logic is_read;
		logic empty;
		logic idx_ok;
		logic cnt_zero;
		logic hit;
		logic last;
	} dp_stat_t;

endpackage

`default_nettype wire

// ===== hdl/address_range_merge_table_core.sv =====
// ----------------------------------------------------------------------------
// address_range_merge_table_core
// Table of address ranges with first-match merge, append and indexed read.
//
// Usage: drive command, range_start, range_end and read_index with start
// high; the transaction is taken on a clock edge where busy is low. Each
// transaction gives exactly one result, shown for one cycle with done high.
// The receiver cannot stall, so results must be taken as they appear.
// Steps: the command is decoded first; an empty range or a bad read index
// ends there, a good read fetches the indexed entry, and an add scans the
// valid entries from slot 0 until the first hit, which it merges, or past
// the last, then appends or is dropped when full (on an empty table it
// appends straight away). The scan reads one memory entry per cycle from
// the single read port; busy covers the whole transaction, so items are
// handled one at a time and start may be held high for the next one.
// Reset clears the valid count and the controller; entry memory is not
// cleared, since no entry is read before it was written.
// ----------------------------------------------------------------------------
`default_nettype none

module address_range_merge_table_core #(
	parameter int unsigned MAX_RANGES = armt_pkg::MAX_RANGES_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire         command,
	input  wire  [63:0] range_start,
	input  wire  [63:0] range_end,
	input  wire  [5:0]  read_index,
	output logic        done,
	output logic [2:0]  status,
	output logic [5:0]  entry_slot,
	output logic [63:0] entry_start,
	output logic [63:0] entry_end,
	output logic [31:0] entry_hits,
	output logic [6:0]  entry_total
);

	armt_pkg::dp_cmd_t  cmd;
	armt_pkg::dp_stat_t stat;

	armt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	armt_dp #(
		.MAX_RANGES (MAX_RANGES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.command     (command),
		.range_start (range_start),
		.range_end   (range_end),
		.read_index  (read_index),
		.cmd         (cmd),
		.stat        (stat),
		.done        (done),
		.status      (status),
		.entry_slot  (entry_slot),
		.entry_start (entry_start),
		.entry_end   (entry_end),
		.entry_hits  (entry_hits),
		.entry_total (entry_total)
	);

endmodule

`default_nettype wire

// ===== hdl/armt_dp.sv =====
// ----------------------------------------------------------------------------
// armt_dp
// Datapath: captured command, entry memory, scan address, valid count,
// merge arithmetic and result registers.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module armt_dp #(
	parameter int unsigned MAX_RANGES = armt_pkg::MAX_RANGES_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 command,
	input  wire  [63:0]         range_start,
	input  wire  [63:0]         range_end,
	input  wire  [5:0]          read_index,
	input  wire armt_pkg::dp_cmd_t cmd,
	output armt_pkg::dp_stat_t  stat,
	output logic                done,
	output logic [2:0]          status,
	output logic [5:0]          entry_slot,
	output logic [63:0]         entry_start,
	output logic [63:0]         entry_end,
	output logic [31:0]         entry_hits,
	output logic [6:0]          entry_total
);

	localparam int unsigned IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_RANGES + 1);
	localparam int unsigned CMP_W = (CNT_W > 6) ? CNT_W : 6;

	logic                  cmd_q;
	logic [63:0]           lo_q;
	logic [63:0]           hi_q;
	logic [5:0]            idx_q;
	logic [CNT_W-1:0]      count_q;
	logic [IDX_W-1:0]      scan_next_q;

	armt_pkg::entry_t      mem [MAX_RANGES];
	armt_pkg::entry_t      rd_data_s1;
	logic [IDX_W-1:0]      rd_idx_s1;

	logic                  rd_en;
	logic [IDX_W-1:0]      rd_addr;
	logic                  wr_en;
	logic [IDX_W-1:0]      wr_addr;
	armt_pkg::entry_t      wr_data;
	armt_pkg::entry_t      merged;
	logic                  full;
	logic [CMP_W-1:0]      idx_ext;
	logic [6:0]            total_next;

	armt_pkg::status_t     res_status_q;
	logic [5:0]            res_slot_q;
	armt_pkg::entry_t      res_entry_q;
	logic [6:0]            res_total_q;
	logic                  done_q;

	assign idx_ext = CMP_W'(idx_q);
	assign full    = (count_q == CNT_W'(MAX_RANGES));

	assign stat.is_read  = (cmd_q == armt_pkg::CMD_READ);
	assign stat.empty    = (hi_q <= lo_q);
	assign stat.idx_ok   = (idx_ext < CMP_W'(count_q));
	assign stat.cnt_zero = (count_q == '0);
	// inclusive bounds: ranges that share an endpoint count as overlapping
	assign stat.hit      = !((hi_q < rd_data_s1.lo) || (lo_q > rd_data_s1.hi));
	assign stat.last     = ((CNT_W'(rd_idx_s1) + CNT_W'(1)) == count_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= command;
			lo_q  <= range_start;
			hi_q  <= range_end;
			idx_q <= read_index;
		end
	end

	always_comb begin
		rd_en   = 1'b1;
		rd_addr = scan_next_q;
		case (cmd.rd_sel)
			armt_pkg::RD_FIRST: rd_addr = '0;
			armt_pkg::RD_NEXT:  rd_addr = scan_next_q;
			armt_pkg::RD_INDEX: rd_addr = idx_ext[IDX_W-1:0];
			default:            rd_en   = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_sel == armt_pkg::RD_FIRST) begin
			scan_next_q <= IDX_W'(1);
		end else if (cmd.rd_sel == armt_pkg::RD_NEXT) begin
			scan_next_q <= scan_next_q + IDX_W'(1);
		end
	end

	always_comb begin
		merged.lo   = (lo_q < rd_data_s1.lo) ? lo_q : rd_data_s1.lo;
		merged.hi   = (hi_q > rd_data_s1.hi) ? hi_q : rd_data_s1.hi;
		merged.hits = (rd_data_s1.hits != armt_pkg::HITS_MAX) ?
			rd_data_s1.hits + 32'd1 : rd_data_s1.hits;
	end

	always_comb begin
		wr_en        = 1'b0;
		wr_addr      = rd_idx_s1;
		wr_data      = merged;
		if (cmd.act == armt_pkg::ACT_MERGE) begin
			wr_en = 1'b1;
		end else if ((cmd.act == armt_pkg::ACT_TAIL) && !full) begin
			wr_en        = 1'b1;
			wr_addr      = count_q[IDX_W-1:0];
			wr_data.lo   = lo_q;
			wr_data.hi   = hi_q;
			wr_data.hits = 32'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
			rd_idx_s1  <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if ((cmd.act == armt_pkg::ACT_TAIL) && !full) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (cmd.act != armt_pkg::ACT_NONE);
		end
	end

	// count reported with the result, including the entry being appended
	assign total_next = ((cmd.act == armt_pkg::ACT_TAIL) && !full) ?
		7'(count_q + CNT_W'(1)) : 7'(count_q);

	always_ff @(posedge clk) begin
		res_total_q <= total_next;
		unique case (cmd.act)
			armt_pkg::ACT_EMPTY: begin
				res_status_q <= armt_pkg::ST_EMPTY;
				res_slot_q   <= '0;
				res_entry_q  <= '0;
			end
			armt_pkg::ACT_BAD: begin
				res_status_q <= armt_pkg::ST_BAD_INDEX;
				res_slot_q   <= '0;
				res_entry_q  <= '0;
			end
			armt_pkg::ACT_READ: begin
				res_status_q <= armt_pkg::ST_READ_OK;
				res_slot_q   <= 6'(rd_idx_s1);
				res_entry_q  <= rd_data_s1;
			end
			armt_pkg::ACT_MERGE: begin
				res_status_q <= armt_pkg::ST_MERGED;
				res_slot_q   <= 6'(rd_idx_s1);
				res_entry_q  <= merged;
			end
			armt_pkg::ACT_TAIL: begin
				if (full) begin
					res_status_q <= armt_pkg::ST_FULL;
					res_slot_q   <= '0;
					res_entry_q  <= '0;
				end else begin
					res_status_q <= armt_pkg::ST_INSERTED;
					res_slot_q   <= 6'(count_q);
					res_entry_q  <= wr_data;
				end
			end
			default: begin
				res_status_q <= res_status_q;
			end
		endcase
	end

	assign done        = done_q;
	assign status      = res_status_q;
	assign entry_slot  = res_slot_q;
	assign entry_start = res_entry_q.lo;
	assign entry_end   = res_entry_q.hi;
	assign entry_hits  = res_entry_q.hits;
	assign entry_total = res_total_q;

	`ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CNT_W'(MAX_RANGES),
		"valid count above table depth")
	`ASSERT_NEXT(a_act_strobe, clk, arst_n, cmd.act != armt_pkg::ACT_NONE, done_q,
		"result action without strobe")
	`ASSERT_IMPL(a_count_tail, clk, arst_n, count_q != $past(count_q),
		$past(cmd.act) == armt_pkg::ACT_TAIL, "valid count moved outside an insert")

endmodule

`default_nettype wire

// ===== hdl/armt_ctrl.sv =====
// ----------------------------------------------------------------------------
// armt_ctrl
// Controller: sequences decode, table scan, merge or append, and read.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module armt_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	output logic                busy,
	input  wire armt_pkg::dp_stat_t stat,
	output armt_pkg::dp_cmd_t   cmd
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_DECIDE = 6'b000010,
		S_SCAN   = 6'b000100,
		S_READ   = 6'b001000,
		S_MERGE  = 6'b010000,
		S_TAIL   = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.rd_sel = armt_pkg::RD_NONE;
		cmd.act    = armt_pkg::ACT_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (stat.is_read) begin
					if (stat.idx_ok) begin
						cmd.rd_sel = armt_pkg::RD_INDEX;
						state_d    = S_READ;
					end else begin
						cmd.act = armt_pkg::ACT_BAD;
						state_d = S_IDLE;
					end
				end else if (stat.empty) begin
					cmd.act = armt_pkg::ACT_EMPTY;
					state_d = S_IDLE;
				end else if (stat.cnt_zero) begin
					state_d = S_TAIL;
				end else begin
					cmd.rd_sel = armt_pkg::RD_FIRST;
					state_d    = S_SCAN;
				end
			end
			S_SCAN: begin
				// hold the read register on a hit so the merge sees that entry
				if (stat.hit) begin
					state_d = S_MERGE;
				end else if (stat.last) begin
					state_d = S_TAIL;
				end else begin
					cmd.rd_sel = armt_pkg::RD_NEXT;
				end
			end
			S_READ: begin
				cmd.act = armt_pkg::ACT_READ;
				state_d = S_IDLE;
			end
			S_MERGE: begin
				cmd.act = armt_pkg::ACT_MERGE;
				state_d = S_IDLE;
			end
			S_TAIL: begin
				cmd.act = armt_pkg::ACT_TAIL;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	`ASSERT_NEXT(a_scan_no_idle, clk, arst_n, state_q == S_SCAN, state_q != S_IDLE,
		"scan left without merge or append")

endmodule

`default_nettype wire

// ===== verif/address_range_merge_table_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// address_range_merge_table_checker
// Watches the command and result ports of the range table, keeps its own copy
// of the table, predicts each result and compares it with what comes out.
// ----------------------------------------------------------------------------
module address_range_merge_table_checker (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	input  wire         busy,
	input  wire         command,
	input  wire  [63:0] range_start,
	input  wire  [63:0] range_end,
	input  wire  [5:0]  read_index,
	input  wire         done,
	input  wire  [2:0]  status,
	input  wire  [5:0]  entry_slot,
	input  wire  [63:0] entry_start,
	input  wire  [63:0] entry_end,
	input  wire  [31:0] entry_hits,
	input  wire  [6:0]  entry_total,
	output int unsigned fail_count,
	output int unsigned pending
);

	typedef struct packed {
		armt_pkg::status_t st;
		logic [5:0]        slot;
		logic [63:0]       lo;
		logic [63:0]       hi;
		logic [31:0]       hits;
		logic [6:0]        total;
	} range_reply_t;

	logic [63:0]  tab_lo   [armt_pkg::MAX_RANGES_DEF];
	logic [63:0]  tab_hi   [armt_pkg::MAX_RANGES_DEF];
	logic [31:0]  tab_hits [armt_pkg::MAX_RANGES_DEF];
	int unsigned  tab_count;
	range_reply_t reply_q[$];
	int unsigned  shown;

	// applies one command to the table copy and returns the reply it gives
	function automatic range_reply_t apply_range_cmd(input logic cmd, input logic [63:0] lo,
			input logic [63:0] hi, input logic [5:0] idx);
		range_reply_t r;
		logic         matched;
		r = '0;
		matched = 1'b0;
		if (cmd == armt_pkg::CMD_READ) begin
			if (idx < tab_count) begin
				r.st   = armt_pkg::ST_READ_OK;
				r.slot = idx;
				r.lo   = tab_lo[idx];
				r.hi   = tab_hi[idx];
				r.hits = tab_hits[idx];
			end else begin
				r.st = armt_pkg::ST_BAD_INDEX;
			end
		end else if (hi <= lo) begin
			r.st = armt_pkg::ST_EMPTY;
		end else begin
			// first entry that overlaps or touches wins, no coalescing after
			for (int k = 0; k < tab_count && !matched; k++) begin
				if (!(hi < tab_lo[k] || lo > tab_hi[k])) begin
					matched = 1'b1;
					if (lo < tab_lo[k])
						tab_lo[k] = lo;
					if (hi > tab_hi[k])
						tab_hi[k] = hi;
					if (tab_hits[k] != armt_pkg::HITS_MAX)
						tab_hits[k] = tab_hits[k] + 32'd1;
					r.st   = armt_pkg::ST_MERGED;
					r.slot = 6'(k);
					r.lo   = tab_lo[k];
					r.hi   = tab_hi[k];
					r.hits = tab_hits[k];
				end
			end
			if (!matched) begin
				if (tab_count < armt_pkg::MAX_RANGES_DEF) begin
					tab_lo[tab_count]   = lo;
					tab_hi[tab_count]   = hi;
					tab_hits[tab_count] = 32'd1;
					r.st   = armt_pkg::ST_INSERTED;
					r.slot = 6'(tab_count);
					r.lo   = lo;
					r.hi   = hi;
					r.hits = 32'd1;
					tab_count++;
				end else begin
					r.st = armt_pkg::ST_FULL;
				end
			end
		end
		r.total = 7'(tab_count);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		range_reply_t want;
		range_reply_t got;
		logic         bad;
		if (!arst_n) begin
			tab_count  = 0;
			reply_q.delete();
			fail_count = 0;
			pending    = 0;
			shown      = 0;
		end else begin
			if (done) begin
				got.st    = armt_pkg::status_t'(status);
				got.slot  = entry_slot;
				got.lo    = entry_start;
				got.hi    = entry_end;
				got.hits  = entry_hits;
				got.total = entry_total;
				if (reply_q.size() == 0) begin
					fail_count++;
					if (shown < 10) begin
						shown++;
						$display("%0t: result with no transaction outstanding, status %0d",
							$realtime, status);
					end
				end else begin
					want = reply_q.pop_front();
					bad = (got.st !== want.st) || (got.slot !== want.slot) ||
						(got.lo !== want.lo) || (got.hi !== want.hi) ||
						(got.hits !== want.hits) || (got.total !== want.total);
					if (bad) begin
						fail_count++;
						if (shown < 10) begin
							shown++;
							$display("%0t: mismatch status %0d/%0d slot %0d/%0d total %0d/%0d",
								$realtime, want.st, got.st, want.slot, got.slot,
								want.total, got.total);
							$display("  start %h/%h end %h/%h hits %h/%h (exp/got)",
								want.lo, got.lo, want.hi, got.hi, want.hits, got.hits);
						end
					end
				end
			end
			if (start && !busy)
				reply_q.push_back(apply_range_cmd(command, range_start, range_end,
					read_index));
			pending = reply_q.size();
		end
	end

endmodule

// ===== verif/tb_address_range_merge_table_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_address_range_merge_table_core
// Drives add and read transactions into the range table: a directed opening
// on the empty table, then random reads and adds, mostly around a growing set
// of address regions so that merges reach deep slots and the table fills up.
// ----------------------------------------------------------------------------
module tb_address_range_merge_table_core;

	localparam logic        CMD_ADD      = armt_pkg::CMD_ADD;
	localparam logic        CMD_READ     = armt_pkg::CMD_READ;
	localparam logic [63:0] ADDR_MAX     = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam int          RANDOM_ITEMS = 1600;
	localparam int          N_REGIONS    = 96;
	localparam int          CYCLE_LIMIT  = 1000000;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        start       = 1'b0;
	logic        command     = 1'b0;
	logic [63:0] range_start = '0;
	logic [63:0] range_end   = '0;
	logic [5:0]  read_index  = '0;
	logic        busy;
	logic        done;
	logic [2:0]  status;
	logic [5:0]  entry_slot;
	logic [63:0] entry_start;
	logic [63:0] entry_end;
	logic [31:0] entry_hits;
	logic [6:0]  entry_total;

	int unsigned fail_count;
	int unsigned pending;
	int          cycle_count = 0;
	logic        burst = 1'b0;
	logic [63:0] region_base [N_REGIONS];

	always #5 clk = ~clk;

	address_range_merge_table_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.command     (command),
		.range_start (range_start),
		.range_end   (range_end),
		.read_index  (read_index),
		.done        (done),
		.status      (status),
		.entry_slot  (entry_slot),
		.entry_start (entry_start),
		.entry_end   (entry_end),
		.entry_hits  (entry_hits),
		.entry_total (entry_total)
	);

	address_range_merge_table_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.command     (command),
		.range_start (range_start),
		.range_end   (range_end),
		.read_index  (read_index),
		.done        (done),
		.status      (status),
		.entry_slot  (entry_slot),
		.entry_start (entry_start),
		.entry_end   (entry_end),
		.entry_hits  (entry_hits),
		.entry_total (entry_total),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// entered at a rising edge, returns at the edge that takes the transaction
	task automatic send_cmd(input logic cmd, input logic [63:0] lo, input logic [63:0] hi,
			input logic [5:0] idx);
		int unsigned gap;
		gap = burst ? 0 : $urandom_range(0, 12);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start       <= 1'b1;
		command     <= cmd;
		range_start <= lo;
		range_end   <= hi;
		read_index  <= idx;
		@(negedge clk);
		while (busy)
			@(negedge clk);
		@(posedge clk);
	endtask

	// hold off until every transaction has returned its result
	task automatic drain;
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	initial begin
		int unsigned kind;
		int unsigned r;
		int unsigned r_top;
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] lo;
		for (int i = 0; i < N_REGIONS; i++)
			region_base[i] = {$urandom, $urandom} & ~64'hFFFF;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table: reads miss, degenerate ranges rejected
		send_cmd(CMD_READ, '0, '0, 6'd0);
		send_cmd(CMD_READ, ADDR_MAX, ADDR_MAX, 6'd63);
		send_cmd(CMD_ADD, 64'd5, 64'd5, 6'd0);
		send_cmd(CMD_ADD, 64'd10, 64'd3, 6'd0);
		send_cmd(CMD_ADD, ADDR_MAX, '0, 6'd63);
		// insert, merge on a shared endpoint, gap of one stays separate
		send_cmd(CMD_ADD, 64'd0, 64'd1, 6'd0);
		send_cmd(CMD_ADD, 64'd1, 64'd2, 6'd0);
		send_cmd(CMD_ADD, 64'd3, 64'd9, 6'd0);
		send_cmd(CMD_ADD, 64'd9, 64'd20, 6'd0);
		// spans both entries: only the first one grows
		send_cmd(CMD_ADD, 64'd0, 64'd30, 6'd0);
		send_cmd(CMD_READ, '0, '0, 6'd0);
		send_cmd(CMD_READ, '0, '0, 6'd1);
		send_cmd(CMD_READ, '0, '0, 6'd2);
		// top of the address space
		send_cmd(CMD_ADD, ADDR_MAX - 1, ADDR_MAX, 6'd0);
		send_cmd(CMD_ADD, ADDR_MAX - 10, ADDR_MAX - 1, 6'd0);
		send_cmd(CMD_ADD, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0005, 6'd0);
		send_cmd(CMD_READ, ADDR_MAX, '0, 6'd2);
		send_cmd(CMD_READ, '0, ADDR_MAX, 6'd3);
		send_cmd(CMD_READ, '0, '0, 6'd4);
		send_cmd(CMD_ADD, 64'd100, 64'd50, 6'd0);
		drain();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if ($urandom_range(0, 59) == 0)
				burst = !burst;
			kind  = $urandom_range(0, 99);
			// regions come into play gradually so the table fills slowly
			r_top = (n / 12 < N_REGIONS - 1) ? n / 12 : N_REGIONS - 1;
			r     = $urandom_range(0, r_top);
			a     = {$urandom, $urandom};
			b     = {$urandom, $urandom};
			if (kind >= 60 && kind < 65) begin
				lo = (a > b) ? a : b;
				send_cmd(CMD_ADD, lo, (kind == 60) ? lo : ((a > b) ? b : a),
					6'($urandom_range(0, 63)));
			end else if (kind >= 65 && kind < 90) begin
				send_cmd(CMD_READ, a, b, 6'($urandom_range(0, 63)));
			end else if (kind >= 90 && kind < 93 && n >= RANDOM_ITEMS - 150) begin
				// wide range late in the run, swallows many regions
				send_cmd(CMD_ADD, (a > b) ? b : a, (a > b) ? a : b, 6'($urandom_range(0, 63)));
			end else begin
				lo = region_base[r] + 64'($urandom_range(0, 255));
				send_cmd(CMD_ADD, lo, lo + 64'($urandom_range(1, 40)),
					6'($urandom_range(0, 63)));
			end
			if (n % 400 == 399)
				drain();
		end

		drain();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
